// ----- rtl/strp_pkg.sv -----
// Shared types and constants for the serial telemetry response parser.
// Depends on nothing. The parser top level imports it.
`default_nettype none

package strp_pkg;

  // Parser phase while walking through a response frame.
  typedef enum logic [2:0] {
    PhIdle,
    PhDollar,
    PhM,
    PhArrow,
    PhSize,
    PhBody
  } phase_e;

  // Message kind reported with each decoded value.
  typedef enum logic [1:0] {
    KindAttitude = 2'd0,
    KindRawImu   = 2'd1,
    KindRc       = 2'd2,
    KindAnalog   = 2'd3
  } kind_e;

  // Header bytes '$', 'M' and '>'.
  localparam logic [7:0] SyncDollar = 8'h24;
  localparam logic [7:0] SyncM      = 8'h4D;
  localparam logic [7:0] SyncArrow  = 8'h3E;

  // Command codes that carry decoded values.
  localparam logic [7:0] CmdRawImu   = 8'd102;
  localparam logic [7:0] CmdRc       = 8'd105;
  localparam logic [7:0] CmdAttitude = 8'd108;
  localparam logic [7:0] CmdAnalog   = 8'd110;

  // Payload bytes that any decode can reach (six words at most).
  localparam int unsigned DecodeBytes = 12;
  localparam int unsigned MaxValues   = 6;
  localparam int unsigned StoreIdxW   = $clog2(DecodeBytes);
  localparam int unsigned ValueIdxW   = $clog2(MaxValues);

  // Configuration space.
  localparam int unsigned AddrW              = 3;
  localparam logic        RegMaxPayload      = 1'b0;
  localparam logic [7:0]  MaxPayloadResetVal = 8'd50;

endpackage

`default_nettype wire

// ----- rtl/serial_telemetry_response_parser.sv -----
// Response frame parser for a byte-wide serial telemetry link.
// Depends on strp_pkg for phase and kind types, header bytes and command codes.
//
//   Channel   Direction  Handshake               Payload
//   -------   ---------  ----------------------  ---------------------------------
//   in        input      in_valid_i / in_ready_o  rx_byte_i
//   out       output     out_valid_o/out_ready_i  msg_kind_o, value_index_o,
//                                                 value_o, last_o
//   config    input      psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// Each byte is taken as it fires, so bytes can arrive back to back. A checksum byte that
// completes a good frame loads the decoded values into the result bank; the first result
// is visible in the next cycle and the 3, 4 or 6 values then leave one per cycle unless
// the result side stalls, which holds the shown result. Only a checksum byte waits:
// while the previous frame still has results other than a final one taken in the same
// cycle. Reset returns to header hunt, empties the bank and sets max_payload to 50.
`default_nettype none

module serial_telemetry_response_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [7:0]                  rx_byte_i,

  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [1:0]                  msg_kind_o,
  output      logic [2:0]                  value_index_o,
  output      logic signed [15:0]          value_o,
  output      logic                        last_o,

  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [strp_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);

  import strp_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register. Register index is the word address bit above the
  // byte offset; writes to other indexes are dropped and read back as zero.
  // ---------------------------------------------------------------------------
  logic [7:0] max_payload_q;
  logic       cfg_hit;
  logic       cfg_we;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == RegMaxPayload);
  assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? {24'b0, max_payload_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadResetVal;
    end else if (cfg_we) begin
      max_payload_q <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Frame parser state.
  // ---------------------------------------------------------------------------
  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] off_q, off_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] store_q [DecodeBytes];
  logic       store_we;

  // Result bank.
  logic                 busy_q;
  logic [ValueIdxW-1:0] idx_q;
  logic [ValueIdxW-1:0] last_idx_q;
  kind_e                kind_q;
  logic [15:0]          words_q [MaxValues];

  logic in_fire;
  logic is_check;
  logic out_fire;
  logic emit_done;
  logic frame_ok;
  logic cmd_known;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign emit_done = out_fire && last_o;

  // The checksum byte is the one that arrives once the whole payload is in.
  assign is_check  = (phase_q == PhBody) && (off_q == len_q);

  // Only a checksum byte can produce results, so only it waits for the bank.
  assign in_ready_o = !is_check || !busy_q || emit_done;

  assign cmd_known = cmd_q inside {CmdAttitude, CmdRawImu, CmdRc, CmdAnalog};
  assign frame_ok  = in_fire && is_check && (xor_q == rx_byte_i) && cmd_known;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    cmd_d    = cmd_q;
    off_d    = off_q;
    xor_d    = xor_q;
    store_we = 1'b0;
    if (in_fire) begin
      case (phase_q)
        PhIdle:   phase_d = (rx_byte_i == SyncDollar) ? PhDollar : PhIdle;
        PhDollar: phase_d = (rx_byte_i == SyncM) ? PhM : PhIdle;
        PhM:      phase_d = (rx_byte_i == SyncArrow) ? PhArrow : PhIdle;
        PhArrow: begin
          // An oversized frame is dropped right at its size byte.
          if (rx_byte_i > max_payload_q) begin
            phase_d = PhIdle;
          end else begin
            len_d   = rx_byte_i;
            off_d   = 8'd0;
            xor_d   = rx_byte_i;
            phase_d = PhSize;
          end
        end
        PhSize: begin
          cmd_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PhBody;
        end
        PhBody: begin
          if (off_q < len_q) begin
            xor_d    = xor_q ^ rx_byte_i;
            store_we = (off_q < 8'(DecodeBytes));
            off_d    = off_q + 8'd1;
          end else begin
            // Checksum byte: the frame ends here whatever it holds.
            phase_d = PhIdle;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      len_q   <= 8'd0;
      cmd_q   <= 8'd0;
      off_q   <= 8'd0;
      xor_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      off_q   <= off_d;
      xor_q   <= xor_d;
    end
  end

  // Payload bytes are never cleared: at decode time every position below the
  // frame length has been written by this frame, and the rest read as zero.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[off_q[StoreIdxW-1:0]] <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode of the finished payload.
  // ---------------------------------------------------------------------------
  logic [7:0]           kept [DecodeBytes];
  logic [15:0]          dec_words [MaxValues];
  kind_e                kind_d;
  logic [ValueIdxW-1:0] last_idx_d;

  always_comb begin
    for (int j = 0; j < DecodeBytes; j++) begin
      kept[j] = (8'(j) < len_q) ? store_q[j] : 8'd0;
    end
    kind_d     = KindAttitude;
    last_idx_d = ValueIdxW'(2);
    for (int i = 0; i < MaxValues; i++) begin
      dec_words[i] = {kept[2*i+1], kept[2*i]};
    end
    case (cmd_q)
      CmdAttitude: begin
        kind_d     = KindAttitude;
        last_idx_d = ValueIdxW'(2);
      end
      CmdRawImu: begin
        kind_d     = KindRawImu;
        last_idx_d = ValueIdxW'(5);
      end
      CmdRc: begin
        kind_d     = KindRc;
        last_idx_d = ValueIdxW'(3);
      end
      CmdAnalog: begin
        // A signed byte first, then three words starting at an odd offset.
        kind_d       = KindAnalog;
        last_idx_d   = ValueIdxW'(3);
        dec_words[0] = {{8{kept[0][7]}}, kept[0]};
        dec_words[1] = {kept[2], kept[1]};
        dec_words[2] = {kept[4], kept[3]};
        dec_words[3] = {kept[6], kept[5]};
      end
      default: begin
        kind_d     = KindAttitude;
        last_idx_d = ValueIdxW'(2);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result bank: loaded by a good frame, drained one value per transaction.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (frame_ok) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_fire) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + ValueIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_ok) begin
      kind_q     <= kind_d;
      last_idx_q <= last_idx_d;
      words_q    <= dec_words;
    end
  end

  assign out_valid_o   = busy_q;
  assign msg_kind_o    = kind_q;
  assign value_index_o = idx_q;
  assign value_o       = words_q[idx_q];
  assign last_o        = (idx_q == last_idx_q);

`ifndef SYNTHESIS
  // A good frame shows its first value in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_ok |=> out_valid_o && (value_index_o == 3'd0))
    else $error("good frame did not start its results");

  // The final value sits at the position that its kind allows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |->
      (msg_kind_o == KindAttitude && value_index_o == 3'd2) ||
      (msg_kind_o == KindRawImu && value_index_o == 3'd5) ||
      (msg_kind_o == KindRc && value_index_o == 3'd3) ||
      (msg_kind_o == KindAnalog && value_index_o == 3'd3))
    else $error("last flag at a wrong position");

  // Taking a value that is not the last one moves on to the next position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && (value_index_o == $past(value_index_o) + 3'd1))
    else $error("result sequence skipped or stopped");

  // The payload offset never runs past the frame length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhBody) |-> (off_q <= len_q))
    else $error("payload offset beyond frame length");
`endif

endmodule

`default_nettype wire
